FILE: sv/lcs_pkg.sv
// ----------------------------------------------------------------------------
// Longest common substring package
// Shared sizes, command and status types for the core and its parts.
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int MaxLen    = 256;
   localparam int AddrWidth = $clog2(MaxLen);
   localparam int CntWidth  = AddrWidth + 1;
   localparam int CharWidth = 8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load_first;   // append request byte to first string
      logic                 load_second;  // append request byte to second string
      logic                 start;        // clear row and best, set i and j
      logic                 rd_issue;     // read first[i] and second[j-1], row[j-1]
      logic                 cell_update;  // apply one cell of the recurrence
      logic                 next_row;     // advance i, reset j
      logic                 clear_job;    // counts and flag back to zero
      logic                 rsp_load;     // capture the result
   } lcs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;     // either string empty
      logic j_last;    // current column is the first one (j == 1)
      logic i_last;    // current row is the last one
   } lcs_status_type;

endpackage

FILE: sv/lcs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcs_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/lcs_datapath.sv
// ----------------------------------------------------------------------------
// Longest common substring datapath
// Character stores, the run-length row memory and the dynamic program cell.
// ----------------------------------------------------------------------------
module lcs_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lcs_pkg::lcs_cmd_type                cmd,
   output lcs_pkg::lcs_status_type             status,
   input  logic [lcs_pkg::CharWidth-1:0]       req_char_code,
   output logic [lcs_pkg::CntWidth-1:0]        rsp_match_length,
   output logic                                rsp_overflow
);

   logic [lcs_pkg::CntWidth-1:0] first_count_ff, first_count_in;
   logic [lcs_pkg::CntWidth-1:0] second_count_ff, second_count_in;
   logic                         dropped_ff, dropped_in;
   logic [lcs_pkg::CntWidth-1:0] i_ff, i_in;
   logic [lcs_pkg::CntWidth-1:0] j_ff, j_in;
   logic [lcs_pkg::CntWidth-1:0] best_ff, best_in;
   logic [lcs_pkg::CntWidth-1:0] len_ff;
   logic                         ovf_ff;
   // Valid bits for row entries 1..MaxLen; entry 0 is always zero.
   logic [lcs_pkg::MaxLen:1] row_vld_ff, row_vld_in;

   logic [lcs_pkg::CharWidth-1:0] a_rd, b_rd;
   logic [lcs_pkg::CntWidth-1:0]  row_rd;
   logic [lcs_pkg::CntWidth-1:0]  prev_run;
   logic [lcs_pkg::CntWidth-1:0]  run_val;
   logic [lcs_pkg::CntWidth-1:0]  jm1;
   logic                          first_full, second_full;
   logic                          row_wr;
   logic [lcs_pkg::AddrWidth-1:0] a_wr_addr, b_wr_addr;
   logic [lcs_pkg::AddrWidth-1:0] row_wr_addr;
   logic [lcs_pkg::AddrWidth-1:0] row_rd_addr;
   logic                          prev_vld_ff;

   assign first_full  = first_count_ff[lcs_pkg::CntWidth-1];
   assign second_full = second_count_ff[lcs_pkg::CntWidth-1];
   assign a_wr_addr   = first_count_ff[lcs_pkg::AddrWidth-1:0];
   assign b_wr_addr   = second_count_ff[lcs_pkg::AddrWidth-1:0];
   assign jm1         = j_ff - lcs_pkg::CntWidth'(1);

   // Row memory holds run[j] at address j-1; run[0] reads as zero.
   assign row_rd_addr = jm1[lcs_pkg::AddrWidth-1:0] - lcs_pkg::AddrWidth'(1);
   assign row_wr_addr = jm1[lcs_pkg::AddrWidth-1:0];

   lcs_ram #(.Width(lcs_pkg::CharWidth), .Depth(lcs_pkg::MaxLen)) u_first (
      .clock, .wr_en(cmd.load_first & ~first_full), .wr_addr(a_wr_addr),
      .wr_data(req_char_code), .rd_addr(i_ff[lcs_pkg::AddrWidth-1:0]), .rd_data(a_rd));

   lcs_ram #(.Width(lcs_pkg::CharWidth), .Depth(lcs_pkg::MaxLen)) u_second (
      .clock, .wr_en(cmd.load_second & ~second_full), .wr_addr(b_wr_addr),
      .wr_data(req_char_code), .rd_addr(jm1[lcs_pkg::AddrWidth-1:0]), .rd_data(b_rd));

   lcs_ram #(.Width(lcs_pkg::CntWidth), .Depth(lcs_pkg::MaxLen)) u_row (
      .clock, .wr_en(row_wr), .wr_addr(row_wr_addr), .wr_data(run_val),
      .rd_addr(row_rd_addr), .rd_data(row_rd));

   // Previous column run, zero at column zero or when never written this job.
   assign prev_run = prev_vld_ff ? row_rd : '0;
   assign run_val  = (a_rd == b_rd) ? prev_run + lcs_pkg::CntWidth'(1) : '0;
   assign row_wr   = cmd.cell_update;

   assign status.empty  = (first_count_ff == '0) || (second_count_ff == '0);
   assign status.j_last = (j_ff == lcs_pkg::CntWidth'(1));
   assign status.i_last = (i_ff == first_count_ff - lcs_pkg::CntWidth'(1));

   // Next-state logic for counters and the cell.
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      best_in         = best_ff;
      row_vld_in      = row_vld_ff;
      if (cmd.load_first) begin
         if (first_full) dropped_in = 1'b1;
         else first_count_in = first_count_ff + lcs_pkg::CntWidth'(1);
      end
      if (cmd.load_second) begin
         if (second_full) dropped_in = 1'b1;
         else second_count_in = second_count_ff + lcs_pkg::CntWidth'(1);
      end
      if (cmd.start) begin
         i_in       = '0;
         j_in       = second_count_in;
         best_in    = '0;
         row_vld_in = '0;
      end
      if (cmd.cell_update) begin
         row_vld_in[j_ff[lcs_pkg::AddrWidth:0]] = 1'b1;
         if (run_val > best_ff) best_in = run_val;
         j_in = jm1;
      end
      if (cmd.next_row) begin
         i_in = i_ff + lcs_pkg::CntWidth'(1);
         j_in = second_count_ff;
      end
      if (cmd.clear_job) begin
         first_count_in  = '0;
         second_count_in = '0;
         dropped_in      = 1'b0;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      best_ff     <= best_in;
      row_vld_ff  <= row_vld_in;
      if (cmd.rd_issue) begin
         prev_vld_ff <= (jm1 != '0) && row_vld_ff[jm1[lcs_pkg::AddrWidth:0]];
      end
      if (cmd.rsp_load) begin
         len_ff <= status.empty ? '0 : best_ff;
         ovf_ff <= dropped_ff;
      end
   end

   assign rsp_match_length = len_ff;
   assign rsp_overflow     = ovf_ff;

endmodule

FILE: sv/lcs_ctrl.sv
// ----------------------------------------------------------------------------
// Longest common substring controller
// Sequences loading, the row-by-row scan and the response handshake.
// ----------------------------------------------------------------------------
module lcs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_opcode,
   input  logic                    req_last_char,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lcs_pkg::lcs_cmd_type    cmd,
   input  lcs_pkg::lcs_status_type status
);

   typedef enum logic [2:0] {
      LOAD, START, READ, CELL, RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;

   assign req_ready = (state_ff == LOAD);
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      // The output register empties when the response is taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         LOAD: begin
            if (req_fire) begin
               cmd.load_first  = ~req_opcode;
               cmd.load_second = req_opcode;
               if (req_opcode && req_last_char) begin
                  cmd.start = 1'b1;
                  state_in  = START;
               end
            end
         end
         START: begin
            state_in = status.empty ? RESULT : READ;
         end
         READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = CELL;
         end
         CELL: begin
            cmd.cell_update = 1'b1;
            if (!status.j_last) begin
               state_in = READ;
            end else if (!status.i_last) begin
               cmd.cell_update = 1'b1;
               cmd.next_row    = 1'b1;
               state_in        = READ;
            end else begin
               state_in = RESULT;
            end
         end
         RESULT: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load  = 1'b1;
               cmd.clear_job = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = LOAD;
            end
         end
         default: state_in = LOAD;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/longest_common_substring_length_core.sv
// ----------------------------------------------------------------------------
// Longest common substring length core
// Loads two byte strings and reports the longest common substring length.
// ----------------------------------------------------------------------------
// Characters load at one per cycle in the load state; after the last second-string
// character each of the n1*n2 cells takes a read state then an update state, as the
// stores and row memory have registered reads; an empty string skips the scan.
// Throughput: a new pair loads while the response waits; a finished scan waits for
// the output register. Reset: synchronous, active high; clears counts and control.
module longest_common_substring_length_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_opcode,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [8:0] rsp_match_length,
   output logic       rsp_overflow
);

   lcs_pkg::lcs_cmd_type    cmd;
   lcs_pkg::lcs_status_type status;

   lcs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_last_char,
      .rsp_valid, .rsp_ready, .cmd, .status);

   lcs_datapath u_dp (
      .clock, .reset, .cmd, .status, .req_char_code,
      .rsp_match_length, .rsp_overflow);

endmodule

FILE: sv/lcs_checker.sv
// ----------------------------------------------------------------------------
// Longest common substring checker
// Port-level properties of the core, bound to the top level.
// ----------------------------------------------------------------------------
module lcs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [8:0] rsp_match_length,
   input logic       rsp_overflow
);

   // A pending response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_match_length) && $stable(rsp_overflow))
      else $error("response changed while stalled");

   // A pending response stays valid until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Length never exceeds the store size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_length <= 9'd256)
      else $error("length out of range");

   // After reset nothing is pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind longest_common_substring_length_core lcs_checker u_lcs_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_match_length, .rsp_overflow);
